/* rtl/core/ucd_pkg.sv */
// Package for the UTF-8 code point decoder: field widths, code point limits,
// the result record and the range check on a finished sequence.
// No dependencies; every rtl/core file refers to it by scoped names.
package ucd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CpW       = 21;
  localparam int unsigned OutDataW  = 24;  // code point padded to whole bytes
  localparam int unsigned CntW      = 2;

  localparam logic [CpW-1:0] CpReplace  = 21'h00FFFD;
  localparam logic [CpW-1:0] CpMin2     = 21'h000080;
  localparam logic [CpW-1:0] CpMin3     = 21'h000800;
  localparam logic [CpW-1:0] CpSurrLo   = 21'h00D800;
  localparam logic [CpW-1:0] CpSurrHi   = 21'h00E000;
  localparam logic [CpW-1:0] CpMin4     = 21'h010000;
  localparam logic [CpW-1:0] CpLimit    = 21'h110000;

  // Continuation byte counts by lead byte class
  localparam logic [CntW-1:0] LenTwoByte   = 2'd1;
  localparam logic [CntW-1:0] LenThreeByte = 2'd2;
  localparam logic [CntW-1:0] LenFourByte  = 2'd3;

  // One decoded result
  typedef struct packed {
    logic [CpW-1:0] codepoint;
    logic           replaced;
  } ucd_result_t;

  // Reject overlong forms, surrogates and values past the Unicode range
  function automatic logic value_ok(input logic [CpW-1:0] v, input logic [CntW-1:0] len);
    logic ok;
    if (len == LenTwoByte) begin
      ok = (v >= CpMin2);
    end else if (len == LenThreeByte) begin
      ok = (v >= CpMin3) && ((v < CpSurrLo) || (v >= CpSurrHi));
    end else begin
      ok = (v >= CpMin4) && (v < CpLimit);
    end
    return ok;
  endfunction

endpackage

/* rtl/core/ucd_in_reg.sv */
// Input register of the UTF-8 decoder: holds one byte until the decode
// stage takes it. Depends on ucd_pkg for the byte width.
module ucd_in_reg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ucd_pkg::ByteW-1:0]  in_byte,
  input  logic                       take,
  output logic                       hold_valid,
  output logic [ucd_pkg::ByteW-1:0]  hold_byte
);

  logic                      valid_r;
  logic [ucd_pkg::ByteW-1:0] byte_r;

  // Accept a new transaction when empty or when the held byte leaves now
  assign in_ready   = !valid_r || take;
  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Capture the byte
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_byte;
    end
  end

endmodule

/* rtl/core/ucd_step.sv */
// Decode stage of the UTF-8 decoder: sequence state and the per-byte update.
// Depends on ucd_pkg for widths, limits, the result record and value_ok.
module ucd_step (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [ucd_pkg::ByteW-1:0]  byte_in,
  output logic                       res_valid,
  output ucd_pkg::ucd_result_t       res
);

  logic [ucd_pkg::CntW-1:0] left_r, left_nxt;
  logic [ucd_pkg::CpW-1:0]  part_r, part_nxt;
  logic [ucd_pkg::CntW-1:0] len_r, len_nxt;
  logic [ucd_pkg::CpW-1:0]  shifted;
  logic [ucd_pkg::CntW-1:0] left_dec;

  assign shifted  = {part_r[ucd_pkg::CpW-7:0], byte_in[5:0]};
  assign left_dec = left_r - 2'd1;

  // Compute result and next state for one byte
  always_comb begin
    left_nxt      = left_r;
    part_nxt      = part_r;
    len_nxt       = len_r;
    res_valid     = 1'b0;
    res.codepoint = ucd_pkg::CpReplace;
    res.replaced  = 1'b1;
    if (left_r != '0) begin
      if (byte_in[7:6] != 2'b10) begin
        // Bad continuation: drop the sequence, consume the byte
        left_nxt  = '0;
        part_nxt  = '0;
        res_valid = 1'b1;
      end else begin
        left_nxt = left_dec;
        if (left_dec != '0) begin
          part_nxt = shifted;
        end else begin
          part_nxt  = '0;
          res_valid = 1'b1;
          if (ucd_pkg::value_ok(shifted, len_r)) begin
            res.codepoint = shifted;
            res.replaced  = 1'b0;
          end
        end
      end
    end else begin
      priority if (byte_in[7] == 1'b0) begin
        res_valid     = 1'b1;
        res.codepoint = {{(ucd_pkg::CpW-ucd_pkg::ByteW){1'b0}}, byte_in};
        res.replaced  = 1'b0;
      end else if (byte_in[7:5] == 3'b110) begin
        part_nxt = {{(ucd_pkg::CpW-5){1'b0}}, byte_in[4:0]};
        len_nxt  = ucd_pkg::LenTwoByte;
        left_nxt = ucd_pkg::LenTwoByte;
      end else if (byte_in[7:4] == 4'b1110) begin
        part_nxt = {{(ucd_pkg::CpW-4){1'b0}}, byte_in[3:0]};
        len_nxt  = ucd_pkg::LenThreeByte;
        left_nxt = ucd_pkg::LenThreeByte;
      end else if (byte_in[7:3] == 5'b11110) begin
        part_nxt = {{(ucd_pkg::CpW-3){1'b0}}, byte_in[2:0]};
        len_nxt  = ucd_pkg::LenFourByte;
        left_nxt = ucd_pkg::LenFourByte;
      end else begin
        // Stray continuation or lead 0xF8 and above
        res_valid = 1'b1;
      end
    end
  end

  // Advance sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      part_r <= '0;
      len_r  <= '0;
    end else if (en) begin
      left_r <= left_nxt;
      part_r <= part_nxt;
      len_r  <= len_nxt;
    end
  end

endmodule

/* rtl/core/utf8_codepoint_decoder_unit.sv */
// Top level of the UTF-8 code point decoder: input register, decode stage
// and result register. Depends on ucd_pkg, ucd_in_reg and ucd_step.
//
//  channel  | direction | tdata                    | tuser
//  ---------+-----------+--------------------------+---------------
//  in_      | slave     | [7:0] byte_in            | -
//  out_     | master    | [20:0] codepoint, 0 pad  | [0] replaced
//
// One byte per cycle sustained while results are taken; after its last byte is
// accepted, a result passes the input register, then the result register.
// Bytes that continue a pending sequence give no result.
// Reset (rst_n low, synchronous) clears the pending sequence and both valids.
// A stalled result holds in the result register while the input register
// still takes one more byte; the decode stage waits only when both are full.
module utf8_codepoint_decoder_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ucd_pkg::ByteW-1:0]      in_tdata,   // [7:0] byte_in
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ucd_pkg::OutDataW-1:0]   out_tdata,  // [20:0] codepoint, [23:21] zero
  output logic [0:0]                     out_tuser   // [0] replaced
);

  logic                      hold_valid;
  logic [ucd_pkg::ByteW-1:0] hold_byte;
  logic                      take;
  logic                      step_valid;
  ucd_pkg::ucd_result_t      step_res;
  logic                      out_valid_r;
  ucd_pkg::ucd_result_t      out_res_r;

  // Decode a held byte when the result register is free
  assign take = hold_valid && (!out_valid_r || out_tready);

  ucd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .take       (take),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  ucd_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (take),
    .byte_in   (hold_byte),
    .res_valid (step_valid),
    .res       (step_res)
  );

  // Load or drain the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= step_valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && step_valid) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(ucd_pkg::OutDataW-ucd_pkg::CpW){1'b0}}, out_res_r.codepoint};
  assign out_tuser  = out_res_r.replaced;

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for utf8_codepoint_decoder_unit: streams bytes, predicts
// decoded code points in a local model and checks every output transaction.
// Depends on ucd_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module testbench;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [ucd_pkg::ByteW-1:0]     in_tdata = '0;     // [7:0] byte_in
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [ucd_pkg::OutDataW-1:0]  out_tdata;         // [20:0] codepoint, [23:21] zero
  logic [0:0]                    out_tuser;         // [0] replaced

  // Decoder state mirrored by the predictor
  logic [ucd_pkg::CntW-1:0]      awaiting = '0;     // continuation bytes still due
  logic [ucd_pkg::CpW-1:0]       gathered = '0;     // value bits collected so far
  logic [ucd_pkg::CntW-1:0]      lead_len = '0;     // continuation count of open sequence

  ucd_pkg::ucd_result_t          expected_cps [$];

  int unsigned                   mismatches = 0;
  int unsigned                   bytes_sent = 0;
  int unsigned                   results_seen = 0;
  int unsigned                   replaced_seen = 0;
  int unsigned                   burst_left = 0;
  logic [9:0]                    stall_cycle = '0;

  utf8_codepoint_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the pipeline hangs
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    mismatches++;
  endtask

  // Advance the decoder model by one byte; returns 1 when a code point comes out
  function automatic bit utf8_predict(input logic [7:0] b, output ucd_pkg::ucd_result_t r);
    logic [ucd_pkg::CpW-1:0] v;
    logic [ucd_pkg::CpW-1:0] floor_v;
    bit                      ok;
    r = '0;
    r.codepoint = ucd_pkg::CpReplace;
    r.replaced  = 1'b1;
    if (awaiting != '0) begin
      // A byte without the 10 prefix kills the sequence and is swallowed
      if (b[7:6] != 2'b10) begin
        awaiting = '0;
        gathered = '0;
        return 1'b1;
      end
      gathered = {gathered[ucd_pkg::CpW-7:0], b[5:0]};
      awaiting = awaiting - 2'd1;
      if (awaiting != '0) return 1'b0;
      v = gathered;
      gathered = '0;
      // Shortest encoding floor per length, then the surrogate hole and the top
      case (lead_len)
        ucd_pkg::LenTwoByte:   floor_v = ucd_pkg::CpMin2;
        ucd_pkg::LenThreeByte: floor_v = ucd_pkg::CpMin3;
        default:               floor_v = ucd_pkg::CpMin4;
      endcase
      ok = (v >= floor_v) && !(v >= ucd_pkg::CpSurrLo && v < ucd_pkg::CpSurrHi) &&
           (v < ucd_pkg::CpLimit);
      if (ok) begin
        r.codepoint = v;
        r.replaced  = 1'b0;
      end
      return 1'b1;
    end
    if (!b[7]) begin
      r.codepoint = {{(ucd_pkg::CpW-8){1'b0}}, b};
      r.replaced  = 1'b0;
      return 1'b1;
    end
    // Open a sequence on a lead byte; anything else is replaced at once
    casez (b)
      8'b110?????: begin
        gathered = {{(ucd_pkg::CpW-5){1'b0}}, b[4:0]};
        lead_len = ucd_pkg::LenTwoByte;
      end
      8'b1110????: begin
        gathered = {{(ucd_pkg::CpW-4){1'b0}}, b[3:0]};
        lead_len = ucd_pkg::LenThreeByte;
      end
      8'b11110???: begin
        gathered = {{(ucd_pkg::CpW-3){1'b0}}, b[2:0]};
        lead_len = ucd_pkg::LenFourByte;
      end
      default: return 1'b1;
    endcase
    awaiting = lead_len;
    return 1'b0;
  endfunction

  // Send one byte, idling between bursts; record its expected code point
  task automatic send_byte(input logic [7:0] b);
    ucd_pkg::ucd_result_t r;
    int unsigned          gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 14) : $urandom_range(1, 3);
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    burst_left--;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    if (utf8_predict(b, r)) expected_cps = {expected_cps, r};
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // Receiver: cycle through always-ready, light, heavy and periodic stalls
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 10'd1;
    case (stall_cycle[9:8])
      2'd0:    out_tready <= 1'b1;
      2'd1:    out_tready <= ($urandom_range(0, 3) != 0);
      2'd2:    out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (stall_cycle[3:0] < 4'd5);
    endcase
  end

  // Compare each output transaction with the oldest expected code point
  always @(posedge clk) begin : check_results
    ucd_pkg::ucd_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_cps.size() == 0) begin
        report_mismatch("unexpected result", 0, 32'(out_tdata));
      end else begin
        want = expected_cps.pop_front();
        if (out_tdata[ucd_pkg::CpW-1:0] != want.codepoint)
          report_mismatch("codepoint", 32'(want.codepoint),
                          32'(out_tdata[ucd_pkg::CpW-1:0]));
        if (out_tuser[0] != want.replaced)
          report_mismatch("replaced flag", 32'(want.replaced), 32'(out_tuser[0]));
        if (out_tdata[ucd_pkg::OutDataW-1:ucd_pkg::CpW] != '0)
          report_mismatch("tdata padding", 0,
                          32'(out_tdata[ucd_pkg::OutDataW-1:ucd_pkg::CpW]));
        if (want.replaced) replaced_seen++;
      end
    end
  end

  // Plain ASCII at both ends of the range
  task automatic test_ascii();
    send_byte(8'h00);
    send_byte(8'h7F);
  endtask

  // Shortest two-byte value, a genuine U+FFFD, and the highest scalar value
  task automatic test_valid_sequences();
    send_byte(8'hC2); send_byte(8'h80);
    send_byte(8'hEF); send_byte(8'hBF); send_byte(8'hBD);
    send_byte(8'hF4); send_byte(8'h8F); send_byte(8'hBF); send_byte(8'hBF);
  endtask

  // Stray continuation, 0xF8-and-up lead, overlong C0 form, surrogate,
  // value past the Unicode range, and a bad continuation that gets swallowed
  task automatic test_invalid_sequences();
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'hC0); send_byte(8'h80);
    send_byte(8'hED); send_byte(8'hA0); send_byte(8'h80);
    send_byte(8'hF4); send_byte(8'h90); send_byte(8'h80); send_byte(8'h80);
    send_byte(8'hC3); send_byte(8'h41);
  endtask

  // Mostly well-formed sequences with random content, plus broken runs and noise
  task automatic test_random_traffic(input int unsigned count);
    int unsigned start;
    int unsigned kind;
    int unsigned conts;
    int unsigned k;
    logic [7:0]  junk;
    start = bytes_sent;
    while (bytes_sent - start < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        send_byte(8'($urandom_range(0, 127)));
      end else if (kind < 45) begin
        send_byte(8'($urandom_range(8'hC0, 8'hDF)));
        send_byte(cont_byte());
      end else if (kind < 65) begin
        // Lean on E0 and ED so overlong and surrogate values show up often
        k = $urandom_range(0, 3);
        send_byte(k == 0 ? 8'hE0 : k == 1 ? 8'hED : 8'($urandom_range(8'hE0, 8'hEF)));
        send_byte(cont_byte());
        send_byte(cont_byte());
      end else if (kind < 82) begin
        k = $urandom_range(0, 3);
        send_byte(k == 0 ? 8'hF0 : k == 1 ? 8'hF4 : 8'($urandom_range(8'hF0, 8'hF7)));
        for (k = 0; k < 3; k++) send_byte(cont_byte());
      end else if (kind < 92) begin
        // Cut a sequence short with a byte that is not a continuation
        k = $urandom_range(0, 2);
        send_byte(k == 0 ? 8'($urandom_range(8'hC0, 8'hDF)) :
                  k == 1 ? 8'($urandom_range(8'hE0, 8'hEF)) :
                           8'($urandom_range(8'hF0, 8'hF7)));
        conts = $urandom_range(0, k);
        for (k = 0; k < conts; k++) send_byte(cont_byte());
        junk = 8'($urandom);
        if (junk[7:6] == 2'b10) junk[6] = 1'b1;
        send_byte(junk);
      end else begin
        send_byte(8'($urandom));
      end
    end
  endtask

  // Leave a sequence open at the end of the stream: no result may appear
  task automatic test_truncated_tail();
    send_byte(8'hE2);
    send_byte(8'h82);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_ascii();
    test_valid_sequences();
    test_invalid_sequences();
    test_random_traffic(750);
    test_truncated_tail();
    in_tvalid <= 1'b0;
    while (expected_cps.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Streamed %0d bytes, checked %0d code points (%0d replacements)",
             bytes_sent, results_seen, replaced_seen);
    $display("Sender ran in random bursts; receiver cycled through four stall patterns");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/ucd_pkg.sv
rtl/core/ucd_in_reg.sv
rtl/core/ucd_step.sv
rtl/core/utf8_codepoint_decoder_unit.sv
tb/sv/testbench.sv
